### rtl/hpts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpts_pkg
// Shared types, constants and the PES header byte table for the packetizer.
// ----------------------------------------------------------------------------
package hpts_pkg;

    localparam int MAX_UNIT_BYTES_DEF = 1048576;
    localparam int PACKET_BYTES       = 188;
    localparam int TS_HEAD_BYTES      = 4;
    localparam int PES_HEAD_BYTES     = 20;
    localparam int CMD_DEPTH          = 4;

    localparam logic [7:0] PKT_SYNC    = 8'h47;
    localparam logic [7:0] STUFF_BYTE  = 8'hFF;
    localparam logic [7:0] STREAM_DEF  = 8'hE0;

    typedef enum logic {
        REG_PACKET_ID   = 1'b0,
        REG_STREAM_CODE = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TS,
        S_STUFF,
        S_PES,
        S_DATA
    } t_back_state;

    typedef struct packed {
        logic [7:0]  data;
        logic        new_pkt;
        logic        unit;
        logic [7:0]  stuff;
        logic [32:0] pts;
        logic        pkt_end;
    } t_cmd;

    function automatic logic [7:0] pes_byte(input logic [4:0] idx,
                                            input logic [32:0] pts,
                                            input logic [7:0] sc);
        logic [7:0] b;
        begin
            unique case (idx)
                5'd0, 5'd1, 5'd4, 5'd5, 5'd14, 5'd15, 5'd16: b = 8'h00;
                5'd2, 5'd17: b = 8'h01;
                5'd3:  b = sc;
                5'd6, 5'd7: b = 8'h80;
                5'd8:  b = 8'h05;
                5'd9:  b = {4'h2, pts[32:30], 1'b1};
                5'd10: b = pts[29:22];
                5'd11: b = {pts[21:15], 1'b1};
                5'd12: b = pts[14:7];
                5'd13: b = {pts[6:0], 1'b1};
                5'd18: b = 8'h09;
                5'd19: b = 8'hF0;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/h264_pes_ts_packetizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h264_pes_ts_packetizer_top
// Access-unit bytes in, 188-byte MPEG-2 transport packets out as 64-bit words.
// ----------------------------------------------------------------------------
// Feed one payload byte per item; the first byte of a unit carries its length
// and 33-bit PTS. Each unit becomes a PES packet (20-byte header, including an
// access-unit delimiter) cut into transport packets with PID, unit start flag
// and a 4-bit continuity counter; a short final packet is padded with an
// adaptation-field stuffing run. Output words hold up to eight bytes, earliest
// byte in bits 63..56, with a byte count, a packet end flag and a run_last flag
// on the last word caused by each item. The front takes one item per cycle
// into a four-entry command queue while it has room; the back generates, for
// each packet, its 4-byte header, any stuffing bytes, the 20-byte PES header
// on a unit start, and the payload, and can stall when the output is not taken.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
module h264_pes_ts_packetizer_top #(
    parameter int MAX_UNIT_BYTES = hpts_pkg::MAX_UNIT_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [12:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_unit_start,
    input  wire  [20:0] i_unit_length,
    input  wire  [32:0] i_time_stamp,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_word_out,
    output logic [3:0]  o_bytes_valid,
    output logic        o_packet_end,
    output logic        o_run_last
);
    logic [12:0]    r_packet_id;
    logic [7:0]     r_stream_code;
    hpts_pkg::t_cmd front_cmd, queue_cmd;
    logic           push, pop, full, empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_id   <= '0;
            r_stream_code <= hpts_pkg::STREAM_DEF;
        end else if (i_cfg_we) begin
            unique case (hpts_pkg::t_reg_idx'(i_cfg_idx))
                hpts_pkg::REG_PACKET_ID:   r_packet_id   <= i_cfg_data;
                hpts_pkg::REG_STREAM_CODE: r_stream_code <= i_cfg_data[7:0];
            endcase
        end
    end

    hpts_front #(.MAX_UNIT_BYTES(MAX_UNIT_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_unit_start(i_unit_start),
        .i_unit_length(i_unit_length), .i_time_stamp(i_time_stamp),
        .i_full(full), .o_push(push), .o_cmd(front_cmd)
    );

    hpts_fifo #(.DEPTH(hpts_pkg::CMD_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(front_cmd), .i_pop(pop),
        .o_cmd(queue_cmd), .o_full(full), .o_empty(empty)
    );

    hpts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(queue_cmd), .i_empty(empty), .o_pop(pop),
        .i_packet_id(r_packet_id), .i_stream_code(r_stream_code),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_word_out(o_word_out), .o_bytes_valid(o_bytes_valid),
        .o_packet_end(o_packet_end), .o_run_last(o_run_last)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bytes_valid != 4'd0) && (o_bytes_valid <= 4'd8))
        else $error("byte count out of range");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_packet_end |-> o_run_last)
        else $error("packet end word not last of its item");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("command queue popped while empty");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("command queue pushed while full");
`endif
endmodule
`default_nettype wire

### rtl/hpts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpts_front
// Accept items, track unit and packet position, issue one command per byte kept.
// ----------------------------------------------------------------------------
module hpts_front #(
    parameter int MAX_UNIT_BYTES = hpts_pkg::MAX_UNIT_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [7:0]        i_data_byte,
    input  wire               i_unit_start,
    input  wire  [20:0]       i_unit_length,
    input  wire  [32:0]       i_time_stamp,
    input  wire               i_full,
    output logic              o_push,
    output hpts_pkg::t_cmd    o_cmd
);
    localparam int LW = $clog2(MAX_UNIT_BYTES + 1);
    localparam int CW = ((LW > 21) ? LW : 21) + 1;
    localparam int ROOM = hpts_pkg::PACKET_BYTES - hpts_pkg::TS_HEAD_BYTES;

    logic [LW-1:0] r_left, n_left;
    logic [7:0]    r_fill, n_fill;
    logic [CW-1:0] len_x, len_eff, rem;
    logic          unit, new_pkt, acc;
    logic [7:0]    stuff, base, fill_nx;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign unit    = (r_left == '0);
    assign new_pkt = unit || (r_fill == 8'd0);

    always_comb begin
        len_x = CW'(i_unit_length);
        if (len_x == '0)
            len_eff = CW'(1);
        else if (len_x > CW'(MAX_UNIT_BYTES))
            len_eff = CW'(MAX_UNIT_BYTES);
        else
            len_eff = len_x;
        rem = unit ? (len_eff + CW'(hpts_pkg::PES_HEAD_BYTES)) : CW'(r_left);
        stuff = (rem < CW'(ROOM)) ? 8'(CW'(ROOM) - rem) : 8'd0;
        if (!new_pkt)
            base = r_fill;
        else
            base = 8'(hpts_pkg::TS_HEAD_BYTES) + stuff
                   + (unit ? 8'(hpts_pkg::PES_HEAD_BYTES) : 8'd0);
        fill_nx = base + 8'd1;
        n_left  = (unit ? LW'(len_eff) : r_left) - LW'(1);
        n_fill  = (fill_nx == 8'(hpts_pkg::PACKET_BYTES)) ? 8'd0 : fill_nx;
    end

    // drop bytes that arrive outside a unit
    assign o_push = acc && (!unit || i_unit_start);

    always_comb begin
        o_cmd.data    = i_data_byte;
        o_cmd.new_pkt = new_pkt;
        o_cmd.unit    = unit;
        o_cmd.stuff   = stuff;
        o_cmd.pts     = i_time_stamp;
        o_cmd.pkt_end = (fill_nx == 8'(hpts_pkg::PACKET_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_fill <= '0;
        end else if (o_push) begin
            r_left <= n_left;
            r_fill <= n_fill;
        end
    end
endmodule
`default_nettype wire

### rtl/hpts_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpts_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hpts_fifo #(
    parameter int DEPTH = hpts_pkg::CMD_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  hpts_pkg::t_cmd  i_cmd,
    input  wire             i_pop,
    output hpts_pkg::t_cmd  o_cmd,
    output logic            o_full,
    output logic            o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hpts_pkg::t_cmd r_mem [DEPTH];
    logic [AW:0]    r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_cmd   = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp[AW-1:0]] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + 1'b1;
            if (i_pop)
                r_rp <= r_rp + 1'b1;
        end
    end
endmodule
`default_nettype wire

### rtl/hpts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpts_back
// Generate the byte stream one byte a cycle unless stalled, pack into words, drive output.
// ----------------------------------------------------------------------------
module hpts_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  hpts_pkg::t_cmd  i_cmd,
    input  wire             i_empty,
    output logic            o_pop,
    input  wire  [12:0]     i_packet_id,
    input  wire  [7:0]      i_stream_code,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [63:0]     o_word_out,
    output logic [3:0]      o_bytes_valid,
    output logic            o_packet_end,
    output logic            o_run_last
);
    hpts_pkg::t_back_state r_state, n_state;
    hpts_pkg::t_cmd r_cmd;
    logic [7:0]  r_cnt, n_cnt;
    logic [3:0]  r_cont;
    logic [55:0] r_buf;
    logic [2:0]  r_bc;
    logic [63:0] r_hold;
    logic [3:0]  r_hold_n;
    logic        r_hold_end, r_hold_v, r_hold_last;

    logic        active, step, emit, is_final, pend, out_free, mv;
    logic [7:0]  byte_v;
    logic [3:0]  cnt;
    logic [63:0] acc, word;

    assign active   = (r_state != hpts_pkg::S_IDLE);
    assign is_final = (r_state == hpts_pkg::S_DATA);
    assign pend     = is_final && r_cmd.pkt_end;
    assign out_free = !o_valid || i_ready;

    // byte source
    always_comb begin
        byte_v = 8'h00;
        unique case (r_state)
            hpts_pkg::S_TS: begin
                unique case (r_cnt[1:0])
                    2'd0: byte_v = hpts_pkg::PKT_SYNC;
                    2'd1: byte_v = {1'b0, r_cmd.unit, 1'b0, i_packet_id[12:8]};
                    2'd2: byte_v = i_packet_id[7:0];
                    2'd3: byte_v = {2'b00, (r_cmd.stuff != 8'd0), 1'b1, r_cont + 4'd1};
                endcase
            end
            hpts_pkg::S_STUFF: begin
                if (r_cnt == 8'd0)
                    byte_v = r_cmd.stuff - 8'd1;
                else if (r_cnt == 8'd1)
                    byte_v = 8'h00;
                else
                    byte_v = hpts_pkg::STUFF_BYTE;
            end
            hpts_pkg::S_PES:  byte_v = hpts_pkg::pes_byte(r_cnt[4:0], r_cmd.pts,
                                                          i_stream_code);
            hpts_pkg::S_DATA: byte_v = r_cmd.data;
            default:          byte_v = 8'h00;
        endcase
    end

    // word packer
    always_comb begin
        acc  = {r_buf, byte_v};
        cnt  = {1'b0, r_bc} + 4'd1;
        emit = (cnt == 4'd8) || pend;
        word = acc << {(4'd8 - cnt), 3'b000};
    end

    // stall when a new word needs the hold slot and it cannot drain
    assign step  = active && !(emit && r_hold_v && !out_free);
    assign mv    = r_hold_v && out_free && ((step && emit) || r_hold_last);
    assign o_pop = !i_empty && ((r_state == hpts_pkg::S_IDLE) || (is_final && step));

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (o_pop) begin
            n_state = i_cmd.new_pkt ? hpts_pkg::S_TS : hpts_pkg::S_DATA;
            n_cnt   = 8'd0;
        end else if (step) begin
            n_cnt = r_cnt + 8'd1;
            unique case (r_state)
                hpts_pkg::S_TS: begin
                    if (r_cnt == 8'd3) begin
                        n_cnt = 8'd0;
                        if (r_cmd.stuff != 8'd0)
                            n_state = hpts_pkg::S_STUFF;
                        else
                            n_state = r_cmd.unit ? hpts_pkg::S_PES : hpts_pkg::S_DATA;
                    end
                end
                hpts_pkg::S_STUFF: begin
                    if (r_cnt == r_cmd.stuff - 8'd1) begin
                        n_cnt   = 8'd0;
                        n_state = r_cmd.unit ? hpts_pkg::S_PES : hpts_pkg::S_DATA;
                    end
                end
                hpts_pkg::S_PES: begin
                    if (r_cnt == 8'(hpts_pkg::PES_HEAD_BYTES - 1)) begin
                        n_cnt   = 8'd0;
                        n_state = hpts_pkg::S_DATA;
                    end
                end
                hpts_pkg::S_DATA: n_state = hpts_pkg::S_IDLE;
                default:          n_state = hpts_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpts_pkg::S_IDLE;
            r_cnt   <= '0;
            r_cont  <= '0;
            r_buf   <= '0;
            r_bc    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (step && r_state == hpts_pkg::S_TS && r_cnt == 8'd3)
                r_cont <= r_cont + 4'd1;
            if (step) begin
                if (emit) begin
                    r_buf <= '0;
                    r_bc  <= '0;
                end else begin
                    r_buf <= acc[55:0];
                    r_bc  <= cnt[2:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_cmd <= i_cmd;
    end

    // hold slot: one word kept back until it is known whether it ends the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v    <= 1'b0;
            r_hold_last <= 1'b0;
        end else if (step && emit) begin
            r_hold_v    <= 1'b1;
            r_hold_last <= is_final;
        end else if (mv) begin
            r_hold_v    <= 1'b0;
            r_hold_last <= 1'b0;
        end else if (step && is_final && r_hold_v) begin
            r_hold_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_hold     <= word;
            r_hold_n   <= cnt;
            r_hold_end <= pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_valid <= 1'b0;
        else if (mv)
            o_valid <= 1'b1;
        else if (i_ready)
            o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (mv) begin
            o_word_out    <= r_hold;
            o_bytes_valid <= r_hold_n;
            o_packet_end  <= r_hold_end;
            o_run_last    <= r_hold_last;
        end
    end
endmodule
`default_nettype wire
